// ===== sv/lfu_page_replacement_defines.svh =====
// Assertion macros used by the LFU page replacement sequencer (lfup_ctrl).
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled while in reset.
`define LFUP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled while in reset.
`define LFUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lfup_pkg.sv =====
// Package with the shared constants and types of the LFU page replacement block.
package lfup_pkg;

    // Fixed port field widths.
    localparam int PAGE_IN_W   = 8;
    localparam int FRAME_IDX_W = 3;
    localparam int FAULT_W     = 16;
    localparam int CFG_W       = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // Parameter defaults.
    localparam int DEF_NUM_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 8;
    localparam int DEF_COUNT_BITS = 16;

    // One result, packed with the hit flag in the lowest bit.
    typedef struct packed {
        logic [FAULT_W-1:0]     fault_total;
        logic [PAGE_IN_W-1:0]   evicted_page;
        logic                   evicted_valid;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   hit;
    } lfup_result_t;

    localparam int RESULT_W = $bits(lfup_result_t);

endpackage

// ===== sv/lfup_table.sv =====
// Frame table memory holding each frame's page number and use count.
module lfup_table
    import lfup_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [PAGE_BITS-1:0]  rd_page,
    output logic [COUNT_BITS-1:0] rd_count,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [PAGE_BITS-1:0]  wr_page,
    input  logic [COUNT_BITS-1:0] wr_count
);

    logic [PAGE_BITS-1:0]  page_mem  [NUM_FRAMES];
    logic [COUNT_BITS-1:0] count_mem [NUM_FRAMES];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_mem[wr_addr]  <= wr_page;
            count_mem[wr_addr] <= wr_count;
        end
    end

    // Registered read port; the data follows in the next cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_page  <= page_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
        end
    end

endmodule

// ===== sv/lfup_ctrl.sv =====
// Sequencer that scans the frame table, picks the frame and writes it back.
`include "lfu_page_replacement_defines.svh"

module lfup_ctrl
    import lfup_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CFG_W-1:0]      frames_in_use,
    // Request side.
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [PAGE_IN_W-1:0]  req_page,
    // Result side.
    output logic                  res_valid,
    input  logic                  res_ready,
    output lfup_result_t          res,
    // Frame table ports.
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [PAGE_BITS-1:0]  rd_page,
    input  logic [COUNT_BITS-1:0] rd_count,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [PAGE_BITS-1:0]  wr_page,
    output logic [COUNT_BITS-1:0] wr_count
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;

    state_t                st_reg, st_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic                  hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic                  empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]      empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic [COUNT_BITS-1:0] min_cnt_reg, min_cnt_next;
    logic [PAGE_BITS-1:0]  min_page_reg, min_page_next;
    logic [FAULT_W-1:0]    fault_reg, fault_next;

    logic [PAGE_BITS-1:0]  page_in;
    logic [7:0]            cfg_ext;
    logic [IDX_W-1:0]      last_cfg;
    logic                  accept;
    logic                  cur_valid;
    logic                  cur_match;
    logic [IDX_W-1:0]      slot;
    logic                  evict;
    logic [FAULT_W-1:0]    fault_upd;
    logic [PAGE_BITS-1:0]  ev_page;

    // Fit the request page to the stored page width.
    for (genvar i = 0; i < PAGE_BITS; i++) begin : g_page_in
        if (i < PAGE_IN_W) begin : g_bit
            assign page_in[i] = req_page[i];
        end else begin : g_zero
            assign page_in[i] = 1'b0;
        end
    end

    // Highest active frame index, with the configured count clamped to 1..NUM_FRAMES.
    assign cfg_ext = {{(8 - CFG_W){1'b0}}, frames_in_use};
    always_comb begin
        if (cfg_ext == 8'd0) begin
            last_cfg = '0;
        end else if (cfg_ext > 8'(NUM_FRAMES)) begin
            last_cfg = IDX_W'(NUM_FRAMES - 1);
        end else begin
            last_cfg = IDX_W'(cfg_ext - 8'd1);
        end
    end

    assign req_ready = (st_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Table reads: frame 0 on accept, then one frame ahead of the scan.
    assign rd_en   = accept || ((st_reg == ST_SCAN) && (idx_reg != last_reg));
    assign rd_addr = (st_reg == ST_SCAN) ? idx_reg + IDX_W'(1) : '0;

    // Entry whose table data is arriving this cycle.
    assign cur_valid = valid_reg[idx_reg];
    assign cur_match = cur_valid && (rd_page == page_reg);

    // Frame choice once the scan is done.
    assign evict   = !hit_found_reg && !empty_found_reg;
    assign slot    = hit_found_reg ? hit_idx_reg :
                     (empty_found_reg ? empty_idx_reg : min_idx_reg);
    assign ev_page = evict ? min_page_reg : '0;
    assign fault_upd = (!hit_found_reg && (fault_reg != FAULT_MAX)) ?
                       fault_reg + FAULT_W'(1) : fault_reg;

    // Write-back of the chosen frame.
    assign res_valid = (st_reg == ST_WRITE);
    assign wr_en     = res_valid && res_ready;
    assign wr_addr   = slot;
    assign wr_page   = page_reg;
    always_comb begin
        if (!hit_found_reg) begin
            wr_count = COUNT_BITS'(1);
        end else if (hit_cnt_reg == '1) begin
            wr_count = hit_cnt_reg;
        end else begin
            wr_count = hit_cnt_reg + COUNT_BITS'(1);
        end
    end

    // Result fields at their port widths.
    assign res.hit           = hit_found_reg;
    assign res.evicted_valid = evict;
    assign res.fault_total   = fault_upd;
    for (genvar i = 0; i < FRAME_IDX_W; i++) begin : g_res_idx
        if (i < IDX_W) begin : g_bit
            assign res.frame_index[i] = slot[i];
        end else begin : g_zero
            assign res.frame_index[i] = 1'b0;
        end
    end
    for (genvar i = 0; i < PAGE_IN_W; i++) begin : g_res_page
        if (i < PAGE_BITS) begin : g_bit
            assign res.evicted_page[i] = ev_page[i];
        end else begin : g_zero
            assign res.evicted_page[i] = 1'b0;
        end
    end

    // Next-state logic of the sequencer and the scan trackers.
    always_comb begin
        st_next          = st_reg;
        idx_next         = idx_reg;
        last_next        = last_reg;
        page_next        = page_reg;
        valid_next       = valid_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        min_idx_next     = min_idx_reg;
        min_cnt_next     = min_cnt_reg;
        min_page_next    = min_page_reg;
        fault_next       = fault_reg;
        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    st_next          = ST_SCAN;
                    idx_next         = '0;
                    last_next        = last_cfg;
                    page_next        = page_in;
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (!hit_found_reg && cur_match) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                    hit_cnt_next   = rd_count;
                end
                if (!empty_found_reg && !cur_valid) begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = idx_reg;
                end
                if ((idx_reg == '0) || (rd_count < min_cnt_reg)) begin
                    min_idx_next  = idx_reg;
                    min_cnt_next  = rd_count;
                    min_page_next = rd_page;
                end
                if (idx_reg == last_reg) begin
                    st_next = ST_WRITE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_WRITE: begin
                if (res_ready) begin
                    st_next          = ST_IDLE;
                    valid_next[slot] = 1'b1;
                    fault_next       = fault_upd;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // State and registered values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            fault_reg <= '0;
        end else begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
            fault_reg <= fault_next;
        end
        idx_reg         <= idx_next;
        last_reg        <= last_next;
        page_reg        <= page_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        min_idx_reg     <= min_idx_next;
        min_cnt_reg     <= min_cnt_next;
        min_page_reg    <= min_page_next;
    end

    // The frame just written back is marked resident.
    `LFUP_ASSERT_NEXT(a_slot_valid, wr_en, valid_reg[$past(wr_addr)], "written frame not valid")
    // The fault total never goes down outside reset.
    `LFUP_ASSERT_NEXT(a_fault_mono, 1'b1, fault_reg >= $past(fault_reg), "fault total dropped")
    // The scan never runs past the last active frame.
    `LFUP_ASSERT_IMPL(a_scan_range, st_reg == ST_SCAN, idx_reg <= last_reg, "scan out of range")

endmodule

// ===== sv/lfu_page_replacement.sv =====
// A new request is taken only once the previous one has been written back; the table is
// read one frame per cycle through its single read port, then the chosen frame is written back.
// A new request is taken while the previous result still waits in the output register.
// Reset clears all frames to empty, the fault total to zero and frames_in_use to 8.
// Top level of the LFU page replacement block.
module lfu_page_replacement
    import lfup_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,  // frames_in_use
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [7:0] page
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] hit, [3:1] frame_index, [4] evicted_valid, [12:5] evicted_page,
    // [28:13] fault_total, [31:29] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    logic [CFG_W-1:0]      frames_reg;
    logic                  m_valid_reg;
    lfup_result_t          m_res_reg;
    logic                  res_valid;
    logic                  res_ready;
    lfup_result_t          res;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [PAGE_BITS-1:0]  wr_page;
    logic [COUNT_BITS-1:0] wr_count;

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            frames_reg <= cfg_wr_data;
        end
    end

    lfup_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frames_in_use (frames_reg),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req_page      (s_tdata[PAGE_IN_W-1:0]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_page       (rd_page),
        .rd_count      (rd_count),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_page       (wr_page),
        .wr_count      (wr_count)
    );

    lfup_table #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_page  (rd_page),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_page  (wr_page),
        .wr_count (wr_count)
    );

    // Output register; it takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, m_res_reg};

endmodule
